/* hdl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Operation codes, status codes and the cell control group shared by the
// bounded deque and its storage cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] K_READ_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] K_READ_BACK  = 3'd5;
    localparam logic [KIND_W-1:0] K_READ_INDEX = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    localparam logic [WORD_W-1:0] WORD_ALL_ONES = '1;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic push_front;  // take the word of the left neighbor
        logic pop_front;   // take the word of the right neighbor
        logic push_back;   // the tail cell takes the pushed word
        logic snap;        // copy the held word into the read line
        logic walk;        // advance the read line one cell toward the front
    } cell_ctl_t;

endpackage

/* hdl/bdq_if.sv */
// ----------------------------------------------------------------------------
// bdq_req_if / bdq_rsp_if
// Valid/ready channels for deque operations and their results.
// ----------------------------------------------------------------------------
interface bdq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         position;

    modport source (output valid, output kind, output value, output position,
                    input ready);
    modport sink   (input valid, input kind, input value, input position,
                    output ready);
endinterface

interface bdq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

/* hdl/bdq_cell.sv */
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque row: holds one word in place order and one
// stage of the read line that carries a word toward the front.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                          clk,
    input  bdq_pkg::cell_ctl_t            ctl,
    input  logic                          at_tail,
    input  logic [bdq_pkg::WORD_W-1:0]    push_value,
    input  logic [bdq_pkg::WORD_W-1:0]    left_data,
    input  logic [bdq_pkg::WORD_W-1:0]    right_data,
    input  logic [bdq_pkg::WORD_W-1:0]    right_rd,
    output logic [bdq_pkg::WORD_W-1:0]    data,
    output logic [bdq_pkg::WORD_W-1:0]    rd
);
    import bdq_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] rd_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push_front)
        begin
            data_next = left_data;
        end
        else if (ctl.pop_front)
        begin
            data_next = right_data;
        end
        else if (ctl.push_back && at_tail)
        begin
            data_next = push_value;
        end
    end

    always_comb
    begin
        rd_next = rd_reg;
        if (ctl.snap)
        begin
            rd_next = data_reg;
        end
        else if (ctl.walk)
        begin
            rd_next = right_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule

/* hdl/bounded_deque_with_indexed_read.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read
// Bounded double-ended queue of 32-bit words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per word: push front/back, pop front/back,
//   read front/back, or read at a position counted from the front. rsp
//   returns one word per operation: read_value and status (ok, empty, full,
//   index out of range). Elements sit in front-to-back order in the cells,
//   cell 0 holding the front; push front and pop front shift the whole row.
//   Pushes, errors and unused codes give their result in the cycle after
//   acceptance. Pops and reads copy the row into a read line that moves
//   one cell toward the front per cycle; the result is registered once the
//   target reaches cell 0. One operation is in flight at a time; the next
//   word is accepted once the read line is done and the result register is
//   free or being taken in that cycle.
//   Reset empties the queue at once; cell contents are not cleared.
//   A stalled rsp holds its result and req.ready stays low until it leaves.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_read #(
    parameter int CAPACITY = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    bdq_req_if.sink      req,
    bdq_rsp_if.source    rsp
);
    import bdq_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = 9;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [IW-1:0]     walk_reg;
    logic [IW-1:0]     walk_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] rd_value_reg;
    logic [WORD_W-1:0] rd_value_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;

    cell_ctl_t         ctl;
    logic              accept;
    logic              full;
    logic              empty;
    logic              in_range;
    logic [IW-1:0]     back_index;

    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [WORD_W-1:0] cell_rd   [CAPACITY];

    assign full       = (count_reg == CW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign in_range   = ({1'b0, req.position} < CMPW'(count_reg));
    assign back_index = IW'(count_reg - CW'(1));

    assign req.ready  = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        rd_value_next  = rd_value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ctl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_value_next = '0;
                    status_next   = ST_OK;
                    case (req.kind)
                        K_PUSH_FRONT, K_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next     = count_reg + CW'(1);
                                ctl.push_front = (req.kind == K_PUSH_FRONT);
                                ctl.push_back  = (req.kind == K_PUSH_BACK);
                            end
                        end
                        K_POP_FRONT, K_POP_BACK, K_READ_FRONT, K_READ_BACK:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.snap   = 1'b1;
                                state_next = S_WALK;
                                if (req.kind == K_POP_FRONT || req.kind == K_READ_FRONT)
                                begin
                                    walk_next = '0;
                                end
                                else
                                begin
                                    walk_next = back_index;
                                end
                                if (req.kind == K_POP_FRONT || req.kind == K_POP_BACK)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                                // drop the front by shifting the row toward cell 0
                                ctl.pop_front = (req.kind == K_POP_FRONT);
                            end
                        end
                        K_READ_INDEX:
                        begin
                            if (in_range)
                            begin
                                ctl.snap   = 1'b1;
                                walk_next  = IW'(req.position);
                                state_next = S_WALK;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_RANGE;
                                rd_value_next  = WORD_ALL_ONES;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (walk_reg == '0)
                begin
                    rd_value_next  = cell_rd[0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.walk  = 1'b1;
                    walk_next = walk_reg - IW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_value_reg <= rd_value_next;
        status_reg   <= status_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [WORD_W-1:0] left_data;
            logic [WORD_W-1:0] right_data;
            logic [WORD_W-1:0] right_rd;
            logic              at_tail;

            assign at_tail = (count_reg == CW'(gi));

            if (gi == 0)
            begin : g_first
                assign left_data = req.value;
            end
            else
            begin : g_inner
                assign left_data = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_data = '0;
                assign right_rd   = '0;
            end
            else
            begin : g_mid
                assign right_data = cell_data[gi+1];
                assign right_rd   = cell_rd[gi+1];
            end

            bdq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .at_tail    (at_tail),
                .push_value (req.value),
                .left_data  (left_data),
                .right_data (right_data),
                .right_rd   (right_rd),
                .data       (cell_data[gi]),
                .rd         (cell_rd[gi])
            );
        end
    endgenerate

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = rd_value_reg;
    assign rsp.status     = status_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full && (req.kind == K_PUSH_FRONT || req.kind == K_PUSH_BACK))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted push did not grow the queue");

    a_walk_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && walk_reg == '0) |=> (rsp.valid && state_reg == S_IDLE))
        else $error("read line finished without a result");

    a_no_accept_in_walk : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !accept)
        else $error("word accepted while the read line is busy");

    a_walk_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (CMPW'(walk_reg) < CMPW'(CAPACITY)))
        else $error("read target beyond the cell row");

endmodule
